// File: sv/acg_pkg.sv
// Shared constants, types and helper functions of the ACK credit gate.
package acg_pkg;

  // Pending queue geometry.
  localparam int QUEUE_DEPTH = 32;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RELEASE = 32;
  localparam int REL_W       = $clog2(MAX_RELEASE + 1);

  // Field widths.
  localparam int TRIG_W  = 20;
  localparam int TAG_W   = 16;
  localparam int LEN_W   = 16;
  localparam int TOS_W   = 8;
  localparam int RTT_W   = 20;
  localparam int TIME_W  = 32;
  localparam int TOK_W   = 24;
  localparam int TRAF_W  = 32;
  localparam int SUM_W   = 40;
  localparam int CNT_W   = 24;
  localparam int RATE_W  = 17;
  localparam int ENTRY_W = TRIG_W + TAG_W;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 40;

  // Congestion-experienced TOS value.
  localparam logic [TOS_W-1:0] CE_TOS = 8'h03;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_OUTGOING = 2'd0;
  localparam logic [OP_W-1:0] OP_INCOMING = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_PASSED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UPDATE   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_TP  = 3'd4;

  // Shared divider sizes.
  localparam int DIV_NW    = 57;
  localparam int DIV_DW    = 33;
  localparam int DIV_CNT_W = $clog2(DIV_NW + 1);

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  // Token addition saturating at the counter maximum.
  function automatic logic [TOK_W-1:0] tok_add(input logic [TOK_W-1:0] tok,
                                               input logic [TRIG_W-1:0] add);
    logic [TOK_W:0] s;
    s = {1'b0, tok} + (TOK_W+1)'(add);
    tok_add = s[TOK_W] ? {TOK_W{1'b1}} : s[TOK_W-1:0];
  endfunction

  // True when the free credit covers the trigger volume.
  function automatic logic credit_ok(input logic [TOK_W-1:0] bucket,
                                     input logic [TOK_W-1:0] tok,
                                     input logic [TRIG_W-1:0] trig);
    logic [TOK_W-1:0] cr;
    cr = (bucket > tok) ? (bucket - tok) : '0;
    credit_ok = (cr >= TOK_W'(trig));
  endfunction

endpackage

// File: sv/acg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/acg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module acg_div
  import acg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0]    nq_q, nq_d;
  logic [DIV_DW-1:0]    rem_q, rem_d;
  logic [DIV_DW-1:0]    den_q, den_d;
  logic [DIV_DW:0]      trial;
  logic                 ge;

  // One subtract-and-compare step; the numerator shifts out as quotient bits shift in.
  always_comb begin
    trial  = {rem_q, nq_q[DIV_NW-1]};
    ge     = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_NW);
      nq_d   = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? DIV_DW'(trial - {1'b0, den_q}) : DIV_DW'(trial);
      nq_d  = {nq_q[DIV_NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = nq_q;

endmodule

// File: sv/ack_credit_gate.sv
// Outgoing ACK credit gate: top level with sequencer, counters and pending queue.
// Outgoing and incoming transactions are accepted in S_IDLE and handled in S_DISP,
// where an outgoing one waits while the output register is full. A tick that closes
// a slot runs up to four shared-divider passes; each released ACK needs a queue read.
// Asynchronous active-low reset initialises counters, queue pointers and control registers;
// the queue memory itself is not cleared, and only written entries are read.
module ack_credit_gate
  import acg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // trigger_bytes[19:0], packet_tag[35:20], pkt_len[51:36], tos_byte[59:52],
  // rtt_us[79:60], now_us[111:80]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tag[15:0], tokens_now[39:16]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind[2:0]
  output logic [KIND_W-1:0]     m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] S_DISP    = 4'd1;
  localparam logic [ST_W-1:0] S_TP_W    = 4'd2;
  localparam logic [ST_W-1:0] S_A_GO    = 4'd3;
  localparam logic [ST_W-1:0] S_A_W     = 4'd4;
  localparam logic [ST_W-1:0] S_M1      = 4'd5;
  localparam logic [ST_W-1:0] S_M2      = 4'd6;
  localparam logic [ST_W-1:0] S_C_GO    = 4'd7;
  localparam logic [ST_W-1:0] S_C_W     = 4'd8;
  localparam logic [ST_W-1:0] S_RTT     = 4'd9;
  localparam logic [ST_W-1:0] S_RTT_W   = 4'd10;
  localparam logic [ST_W-1:0] S_UPD     = 4'd11;
  localparam logic [ST_W-1:0] S_REL_RD  = 4'd12;
  localparam logic [ST_W-1:0] S_REL_CHK = 4'd13;
  localparam logic [ST_W-1:0] S_FIN     = 4'd14;

  localparam int QSUM_W = QCNT_W + 1;
  localparam int PROD_W = TOK_W + RATE_W;

  // Configuration registers.
  logic [TOK_W-1:0]  bucket_q;
  logic [RTT_W-1:0]  min_rtt_q, max_rtt_q;
  logic [RATE_W-1:0] alpha_q, avg_tp_q;

  // Control and working state.
  logic [ST_W-1:0]   state_q, state_d;
  logic [OP_W-1:0]   op_q;
  logic [TRIG_W-1:0] trig_q;
  logic [TAG_W-1:0]  tag_q;
  logic [LEN_W-1:0]  len_q;
  logic [TOS_W-1:0]  tos_q;
  logic [RTT_W-1:0]  rtt_q;
  logic [TIME_W-1:0] now_q;

  logic [TOK_W-1:0]  tokens_q, tokens_d;
  logic [TRAF_W-1:0] traffic_q, traffic_d;
  logic [TRAF_W-1:0] ce_q, ce_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RTT_W-1:0]  avg_rtt_q, avg_rtt_d;
  logic [TIME_W-1:0] last_upd_q, last_upd_d;
  logic [QIDX_W-1:0] head_q, head_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic [REL_W-1:0]  rel_q, rel_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [TOK_W-1:0]  a_q, a_d;
  logic [DIV_NW-1:0] acc_q, acc_d;

  // Result held back until it is known whether it is the last one.
  logic              hold_v_q, hold_v_d;
  logic [KIND_W-1:0] hold_kind_q, hold_kind_d;
  logic [TAG_W-1:0]  hold_tag_q, hold_tag_d;
  logic [TOK_W-1:0]  hold_tok_q, hold_tok_d;

  // Output register.
  logic              m_valid_q, m_valid_d;
  logic [KIND_W-1:0] m_kind_q, m_kind_d;
  logic [TAG_W-1:0]  m_tag_q, m_tag_d;
  logic [TOK_W-1:0]  m_tok_q, m_tok_d;
  logic              m_last_q, m_last_d;

  // Queue memory and divider connections.
  logic               ram_we;
  logic [QIDX_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Datapath helpers.
  logic               in_acc, out_free;
  logic [QSUM_W-1:0]  tail_sum;
  logic [QIDX_W-1:0]  tail;
  logic [TIME_W-1:0]  elapsed;
  logic [DIV_DW-1:0]  two_t;
  logic [PROD_W-1:0]  mul_lo;
  logic [PROD_W-1:0]  mul_hi;
  logic [TRAF_W:0]    traf_sum, ce_sum;
  logic [SUM_W:0]     rsum;
  logic [DIV_NW-1:0]  rtt_lo;
  logic [TRIG_W-1:0]  head_trig;
  logic [TAG_W-1:0]   head_tag;
  logic               new_v, direct_v, flush;
  logic [KIND_W-1:0]  new_kind;
  logic [TAG_W-1:0]   new_tag;
  logic [TOK_W-1:0]   new_tok;

  acg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  acg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Shared arithmetic terms.
  assign tail_sum  = QSUM_W'(head_q) + QSUM_W'(count_q);
  assign tail      = (tail_sum >= QSUM_W'(QUEUE_DEPTH)) ?
                     QIDX_W'(tail_sum - QSUM_W'(QUEUE_DEPTH)) : QIDX_W'(tail_sum);
  assign elapsed   = now_q - last_upd_q;
  assign two_t     = {traffic_q, 1'b0};
  assign mul_lo    = PROD_W'(a_q) * PROD_W'(two_t[16:0]);
  assign mul_hi    = PROD_W'(a_q) * PROD_W'(two_t[DIV_DW-1:17]);
  assign traf_sum  = {1'b0, traffic_q} + (TRAF_W+1)'(len_q);
  assign ce_sum    = {1'b0, ce_q} + (TRAF_W+1)'(len_q);
  assign rsum      = {1'b0, sum_q} + (SUM_W+1)'(rtt_q);
  assign rtt_lo    = (div_rsp.quot < DIV_NW'(min_rtt_q)) ? DIV_NW'(min_rtt_q) : div_rsp.quot;
  assign head_trig = ram_rdata[TRIG_W-1:0];
  assign head_tag  = ram_rdata[ENTRY_W-1:TRIG_W];

  // Sequencer and read-modify-write of the gate state.
  always_comb begin
    state_d     = state_q;
    tokens_d    = tokens_q;
    traffic_d   = traffic_q;
    ce_d        = ce_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    avg_rtt_d   = avg_rtt_q;
    last_upd_d  = last_upd_q;
    head_d      = head_q;
    count_d     = count_q;
    rel_d       = rel_q;
    prod_d      = prod_q;
    a_d         = a_q;
    acc_d       = acc_q;
    ram_we      = 1'b0;
    ram_waddr   = tail;
    ram_wdata   = {tag_q, trig_q};
    div_req     = '0;
    new_v       = 1'b0;
    direct_v    = 1'b0;
    flush       = 1'b0;
    new_kind    = KIND_PASSED;
    new_tag     = tag_q;
    new_tok     = tokens_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_IDLE;
        if (op_q == OP_OUTGOING) begin
          if (!out_free) begin
            state_d = S_DISP;
          end else begin
            direct_v = 1'b1;
            if ((count_q == '0) && credit_ok(bucket_q, tokens_q, trig_q)) begin
              tokens_d = tok_add(tokens_q, trig_q);
              new_tok  = tokens_d;
              new_kind = KIND_PASSED;
            end else if (count_q < QCNT_W'(QUEUE_DEPTH)) begin
              ram_we   = 1'b1;
              count_d  = count_q + 1'b1;
              new_kind = KIND_QUEUED;
            end else begin
              new_kind = KIND_DROPPED;
            end
          end
        end else if (op_q == OP_INCOMING) begin
          traffic_d = traf_sum[TRAF_W] ? {TRAF_W{1'b1}} : traf_sum[TRAF_W-1:0];
          if (tos_q == CE_TOS) begin
            ce_d = ce_sum[TRAF_W] ? {TRAF_W{1'b1}} : ce_sum[TRAF_W-1:0];
          end
          tokens_d = (tokens_q >= TOK_W'(len_q)) ? (tokens_q - TOK_W'(len_q)) : '0;
          sum_d    = rsum[SUM_W] ? {SUM_W{1'b1}} : rsum[SUM_W-1:0];
          if (cnt_q != {CNT_W{1'b1}}) begin
            cnt_d = cnt_q + 1'b1;
          end
        end else if (op_q == OP_TICK) begin
          rel_d = '0;
          if (elapsed > TIME_W'(avg_rtt_q)) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NW'({traffic_q, 3'b000});
            div_req.den   = DIV_DW'(elapsed);
            state_d       = S_TP_W;
          end else begin
            state_d = S_REL_RD;
          end
        end
      end
      // Throughput is ready: decide on the token correction.
      S_TP_W: begin
        if (div_rsp.done) begin
          prod_d = PROD_W'(bucket_q) * PROD_W'(div_rsp.quot[RATE_W-1:0]);
          if ((div_rsp.quot < DIV_NW'(alpha_q)) && (two_t > DIV_DW'(ce_q)) &&
              (avg_tp_q != '0)) begin
            state_d = S_A_GO;
          end else begin
            state_d = S_RTT;
          end
        end
      end
      S_A_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(prod_q);
        div_req.den   = DIV_DW'(avg_tp_q);
        state_d       = S_A_W;
      end
      S_A_W: begin
        if (div_rsp.done) begin
          a_d = div_rsp.quot[TOK_W-1:0];
          if (div_rsp.quot < DIV_NW'(tokens_q)) begin
            state_d = S_M1;
          end else begin
            state_d = S_RTT;
          end
        end
      end
      // Wide product built from two partial products.
      S_M1: begin
        acc_d   = DIV_NW'(mul_lo);
        state_d = S_M2;
      end
      S_M2: begin
        acc_d   = acc_q + (DIV_NW'(mul_hi) << 17);
        state_d = S_C_GO;
      end
      S_C_GO: begin
        div_req.start = 1'b1;
        div_req.num   = acc_q;
        div_req.den   = two_t - DIV_DW'(ce_q);
        state_d       = S_C_W;
      end
      S_C_W: begin
        if (div_rsp.done) begin
          if (div_rsp.quot < DIV_NW'(tokens_q)) begin
            tokens_d = div_rsp.quot[TOK_W-1:0];
          end
          state_d = S_RTT;
        end
      end
      S_RTT: begin
        if (cnt_q != '0) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'(sum_q);
          div_req.den   = DIV_DW'(cnt_q);
          state_d       = S_RTT_W;
        end else begin
          avg_rtt_d = min_rtt_q;
          state_d   = S_UPD;
        end
      end
      S_RTT_W: begin
        if (div_rsp.done) begin
          avg_rtt_d = (rtt_lo > DIV_NW'(max_rtt_q)) ? max_rtt_q : rtt_lo[RTT_W-1:0];
          state_d   = S_UPD;
        end
      end
      // Close the slot; the held result slot is empty here.
      S_UPD: begin
        traffic_d  = '0;
        ce_d       = '0;
        sum_d      = '0;
        cnt_d      = '0;
        last_upd_d = now_q;
        new_v      = 1'b1;
        new_kind   = KIND_UPDATE;
        new_tag    = '0;
        state_d    = S_REL_RD;
      end
      S_REL_RD: begin
        if ((count_q == '0) || (rel_q == REL_W'(MAX_RELEASE))) begin
          state_d = S_FIN;
        end else begin
          state_d = S_REL_CHK;
        end
      end
      S_REL_CHK: begin
        if (!credit_ok(bucket_q, tokens_q, head_trig)) begin
          state_d = S_FIN;
        end else if (!hold_v_q || out_free) begin
          tokens_d = tok_add(tokens_q, head_trig);
          new_v    = 1'b1;
          new_kind = KIND_RELEASED;
          new_tag  = head_tag;
          new_tok  = tokens_d;
          head_d   = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          count_d  = count_q - 1'b1;
          rel_d    = rel_q + 1'b1;
          state_d  = S_REL_RD;
        end
      end
      S_FIN: begin
        if (!hold_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          flush   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register and held result.
  always_comb begin
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_kind_d    = m_kind_q;
    m_tag_d     = m_tag_q;
    m_tok_d     = m_tok_q;
    m_last_d    = m_last_q;
    hold_v_d    = hold_v_q;
    hold_kind_d = hold_kind_q;
    hold_tag_d  = hold_tag_q;
    hold_tok_d  = hold_tok_q;
    if (direct_v) begin
      m_valid_d = 1'b1;
      m_kind_d  = new_kind;
      m_tag_d   = new_tag;
      m_tok_d   = new_tok;
      m_last_d  = 1'b1;
    end else if (new_v) begin
      if (hold_v_q) begin
        m_valid_d = 1'b1;
        m_kind_d  = hold_kind_q;
        m_tag_d   = hold_tag_q;
        m_tok_d   = hold_tok_q;
        m_last_d  = 1'b0;
      end
      hold_v_d    = 1'b1;
      hold_kind_d = new_kind;
      hold_tag_d  = new_tag;
      hold_tok_d  = new_tok;
    end else if (flush) begin
      m_valid_d = 1'b1;
      m_kind_d  = hold_kind_q;
      m_tag_d   = hold_tag_q;
      m_tok_d   = hold_tok_q;
      m_last_d  = 1'b1;
      hold_v_d  = 1'b0;
    end
  end

  // Control and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tokens_q   <= '0;
      traffic_q  <= '0;
      ce_q       <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      avg_rtt_q  <= RTT_W'(100);
      last_upd_q <= '0;
      head_q     <= '0;
      count_q    <= '0;
      rel_q      <= '0;
      hold_v_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      tokens_q   <= tokens_d;
      traffic_q  <= traffic_d;
      ce_q       <= ce_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      avg_rtt_q  <= avg_rtt_d;
      last_upd_q <= last_upd_d;
      head_q     <= head_d;
      count_q    <= count_d;
      rel_q      <= rel_d;
      hold_v_q   <= hold_v_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    a_q         <= a_d;
    acc_q       <= acc_d;
    hold_kind_q <= hold_kind_d;
    hold_tag_q  <= hold_tag_d;
    hold_tok_q  <= hold_tok_d;
    m_kind_q    <= m_kind_d;
    m_tag_q     <= m_tag_d;
    m_tok_q     <= m_tok_d;
    m_last_q    <= m_last_d;
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      trig_q <= s_axis_tdata[19:0];
      tag_q  <= s_axis_tdata[35:20];
      len_q  <= s_axis_tdata[51:36];
      tos_q  <= s_axis_tdata[59:52];
      rtt_q  <= s_axis_tdata[79:60];
      now_q  <= s_axis_tdata[111:80];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q  <= TOK_W'(131072);
      min_rtt_q <= RTT_W'(100);
      max_rtt_q <= RTT_W'(10000);
      alpha_q   <= RATE_W'(900);
      avg_tp_q  <= RATE_W'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BUCKET:  bucket_q  <= cfg_data_i[TOK_W-1:0];
        CFG_MIN_RTT: min_rtt_q <= cfg_data_i[RTT_W-1:0];
        CFG_MAX_RTT: max_rtt_q <= cfg_data_i[RTT_W-1:0];
        CFG_ALPHA:   alpha_q   <= cfg_data_i[RATE_W-1:0];
        CFG_AVG_TP:  avg_tp_q  <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_tok_q, m_tag_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// File: dv/ack_credit_gate_test.sv
// Self-checking testbench for the ACK credit gate with a built-in behavioural predictor.
module ack_credit_gate_test;
  import acg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [TOK_W-1:0]  tok;
    logic              last;
  } gate_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  ack_credit_gate dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor copy of the configuration and state.
  logic [23:0] bucket_q;
  logic [19:0] min_rtt_q, max_rtt_q;
  logic [16:0] alpha_q, avg_tp_q;
  logic [TOK_W-1:0] tokens_q;
  logic [63:0] traffic_q, ce_q, rtt_sum_q;
  logic [31:0] rtt_cnt_q, avg_rtt_q, last_upd_q;
  logic [TRIG_W-1:0] pend_trig[QUEUE_DEPTH];
  logic [TAG_W-1:0] pend_tag[QUEUE_DEPTH];
  int pend_head, pend_count;

  gate_result_t awaited[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit rx_gaps = 1'b1;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TOK_W-1:0] sat_tok(logic [TOK_W-1:0] t, logic [31:0] a);
    logic [31:0] s;
    s = 32'(t) + a;
    return (s > 32'hFFFFFF) ? 24'hFFFFFF : s[23:0];
  endfunction

  function automatic bit covers(logic [TRIG_W-1:0] trig);
    logic [23:0] cr;
    cr = (bucket_q > tokens_q) ? bucket_q - tokens_q : 24'd0;
    return cr >= 24'(trig);
  endfunction

  function automatic void push_result(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag);
    gate_result_t r;
    r.kind = kind; r.tag = tag; r.tok = tokens_q; r.last = 1'b0;
    awaited.push_back(r);
  endfunction

  // Works out the results of one accepted input transaction.
  function automatic void predict_gate(logic [OP_W-1:0] op, logic [TRIG_W-1:0] trig,
      logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len, logic [TOS_W-1:0] tos,
      logic [RTT_W-1:0] rtt, logic [TIME_W-1:0] now);
    int before_n, rel;
    logic [31:0] elapsed;
    logic [63:0] tp, a, two_t, cap, avg;
    before_n = awaited.size();
    if (op == OP_OUTGOING) begin
      if (pend_count == 0 && covers(trig)) begin
        tokens_q = sat_tok(tokens_q, 32'(trig));
        push_result(KIND_PASSED, tag);
      end else if (pend_count < QUEUE_DEPTH) begin
        pend_trig[(pend_head + pend_count) % QUEUE_DEPTH] = trig;
        pend_tag[(pend_head + pend_count) % QUEUE_DEPTH] = tag;
        pend_count++;
        push_result(KIND_QUEUED, tag);
      end else begin
        push_result(KIND_DROPPED, tag);
      end
    end else if (op == OP_INCOMING) begin
      traffic_q = traffic_q + len;
      if (traffic_q > 64'hFFFFFFFF) traffic_q = 64'hFFFFFFFF;
      if (tos == CE_TOS) begin
        ce_q = ce_q + len;
        if (ce_q > 64'hFFFFFFFF) ce_q = 64'hFFFFFFFF;
      end
      tokens_q = (tokens_q >= 24'(len)) ? tokens_q - 24'(len) : 24'd0;
      rtt_sum_q = rtt_sum_q + rtt;
      if (rtt_sum_q > 64'hFF_FFFF_FFFF) rtt_sum_q = 64'hFF_FFFF_FFFF;
      if (rtt_cnt_q < 32'hFFFFFF) rtt_cnt_q++;
    end else if (op == OP_TICK) begin
      elapsed = now - last_upd_q;
      if (elapsed > avg_rtt_q) begin
        // Close the slot: optional token correction, new average RTT.
        last_upd_q = now;
        tp = (traffic_q * 8) / elapsed;
        two_t = 2 * traffic_q;
        if (tp < alpha_q && two_t > ce_q && avg_tp_q != 0) begin
          a = (64'(bucket_q) * tp) / avg_tp_q;
          if (a < tokens_q) begin
            cap = (a * two_t) / (two_t - ce_q);
            if (cap < tokens_q) tokens_q = cap[23:0];
          end
        end
        if (rtt_cnt_q > 0) begin
          avg = rtt_sum_q / rtt_cnt_q;
          if (avg < min_rtt_q) avg = 64'(min_rtt_q);
          if (avg > max_rtt_q) avg = 64'(max_rtt_q);
          avg_rtt_q = avg[31:0];
        end else begin
          avg_rtt_q = 32'(min_rtt_q);
        end
        traffic_q = 0; ce_q = 0; rtt_sum_q = 0; rtt_cnt_q = 0;
        push_result(KIND_UPDATE, '0);
      end
      rel = 0;
      while (pend_count > 0 && rel < MAX_RELEASE && covers(pend_trig[pend_head])) begin
        tokens_q = sat_tok(tokens_q, 32'(pend_trig[pend_head]));
        push_result(KIND_RELEASED, pend_tag[pend_head]);
        pend_head = (pend_head + 1) % QUEUE_DEPTH;
        pend_count--;
        rel++;
      end
    end
    if (awaited.size() > before_n) awaited[$].last = 1'b1;
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    gate_result_t e;
    int g;
    if (m_axis_tvalid && m_axis_tready) begin
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind %0d tag %0h", m_axis_tuser, m_axis_tdata[15:0]);
      end else begin
        e = awaited.pop_front();
        if (m_axis_tuser !== e.kind || m_axis_tdata[15:0] !== e.tag ||
            m_axis_tdata[39:16] !== e.tok || m_axis_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d tag %0h tok %0d last %0b, got %0d %0h %0d %0b",
                     e.kind, e.tag, e.tok, e.last, m_axis_tuser, m_axis_tdata[15:0],
                     m_axis_tdata[39:16], m_axis_tlast);
        end
      end
    end
    // After each accepted result the receiver may pause for a random gap while rx_gaps is set.
    if (!rx_gaps) begin
      rx_wait <= 0;
      m_axis_tready <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else if (m_axis_tvalid && m_axis_tready) begin
      g = gap_len();
      rx_wait <= g;
      m_axis_tready <= (g == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ack_credit_gate_test: errors");
      $finish;
    end
  end

  // Sends one input transaction and records its expected results.
  task automatic send_item(logic [OP_W-1:0] op, logic [TRIG_W-1:0] trig,
      logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len, logic [TOS_W-1:0] tos,
      logic [RTT_W-1:0] rtt, logic [TIME_W-1:0] now, bit gaps = 1'b1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {now, rtt, tos, len, tag, trig};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_gate(op, trig, tag, len, tos, rtt, now);
  endtask

  task automatic release_bus();
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits until every expected result has come, then for the block to settle.
  task automatic drain();
    release_bus();
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_BUCKET:  bucket_q  = val;
      CFG_MIN_RTT: min_rtt_q = val[19:0];
      CFG_MAX_RTT: max_rtt_q = val[19:0];
      CFG_ALPHA:   alpha_q   = val[16:0];
      CFG_AVG_TP:  avg_tp_q  = val[16:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [23:0] b, logic [19:0] mn, logic [19:0] mx,
                         logic [16:0] al, logic [16:0] tp);
    write_reg(CFG_BUCKET, b); write_reg(CFG_MIN_RTT, 24'(mn));
    write_reg(CFG_MAX_RTT, 24'(mx)); write_reg(CFG_ALPHA, 24'(al));
    write_reg(CFG_AVG_TP, 24'(tp));
    cfg_we_i <= 1'b0;
  endtask

  // Directed: field extremes, every operation and the special cases.
  task automatic test_directed();
    logic [TIME_W-1:0] t;
    send_item(OP_OUTGOING, 20'd0, 16'h0000, '0, '0, '0, '0);
    send_item(OP_OUTGOING, 20'd100000, 16'hFFFF, '0, '0, '0, '0);
    send_item(OP_OUTGOING, 20'hFFFFF, 16'h1234, '0, '0, '0, '0);
    send_item(OP_INCOMING, '0, '0, 16'hFFFF, CE_TOS, 20'd1000000, '0);
    send_item(OP_INCOMING, '0, '0, 16'h0000, 8'hFF, 20'd0, '0);
    send_item(2'd3, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 20'hFFFFF, 32'hFFFFFFFF);
    send_item(OP_TICK, '0, '0, '0, '0, '0, 32'd50);
    send_item(OP_TICK, '0, '0, '0, '0, '0, 32'hFFFFFFFF);
    send_item(OP_TICK, '0, '0, '0, '0, '0, 32'd0);
    // Fill the queue past its depth so that drops appear.
    for (int i = 0; i < 36; i++)
      send_item(OP_OUTGOING, 20'hFFFFF, 16'(i), '0, '0, '0, '0, 1'b0);
    drain();
    // Huge bucket lets queued ACKs with large triggers be released and drives tokens towards saturation.
    set_all(24'hFFFFFF, 20'd1, 20'd1000000, 17'd100000, 17'd1);
    t = 32'h10000;
    send_item(OP_INCOMING, '0, '0, 16'd1000, 8'h00, 20'd5, '0);
    send_item(OP_TICK, '0, '0, '0, '0, '0, t);
    send_item(OP_TICK, '0, '0, '0, '0, '0, t + 32'd2000000);
    drain();
  endtask

  // Random traffic: mostly well-formed mixes of ACKs, packets and ticks.
  task automatic test_random(int count, logic [TIME_W-1:0] base);
    logic [TIME_W-1:0] now;
    int r;
    now = base;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_item(OP_OUTGOING, ($urandom_range(0, 9) == 0) ? 20'($urandom) :
                  20'($urandom_range(0, 20000)), 16'($urandom), '0, '0, '0, '0,
                  $urandom_range(0, 3) != 0);
      else if (r < 82)
        send_item(OP_INCOMING, 20'($urandom), 16'($urandom), 16'($urandom),
                  ($urandom_range(0, 2) == 0) ? CE_TOS : 8'($urandom),
                  ($urandom_range(0, 4) == 0) ? 20'd0 : 20'($urandom_range(0, 1000000)),
                  32'($urandom), $urandom_range(0, 3) != 0);
      else if (r < 98) begin
        now = now + (($urandom_range(0, 9) == 0) ? 32'($urandom) :
                     32'($urandom_range(0, 30000)));
        send_item(OP_TICK, 20'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                  20'($urandom), now);
      end else
        send_item(2'd3, 20'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                  20'($urandom), 32'($urandom));
    end
    drain();
  endtask

  task automatic test_config_sweep();
    set_all(24'd0, 20'd1000000, 20'd1, 17'd0, 17'd100000);
    rx_gaps = 1'b0;
    test_random(60, 32'h8000_0000);
    rx_gaps = 1'b1;
    set_all(24'd40000, 20'd1, 20'd50, 17'd100000, 17'd0);
    test_random(90, 32'hFFFF_0000);
    set_all(24'd60000, 20'd20, 20'd4000, 17'd50000, 17'd3);
    test_random(180, 32'h100);
    set_all(24'd131072, 20'd100, 20'd10000, 17'd900, 17'd1000);
    test_random(100, 32'h4000_0000);
  endtask

  initial begin
    bucket_q = 24'd131072; min_rtt_q = 20'd100; max_rtt_q = 20'd10000;
    alpha_q = 17'd900; avg_tp_q = 17'd1000;
    tokens_q = '0; traffic_q = '0; ce_q = '0; rtt_sum_q = '0; rtt_cnt_q = '0;
    avg_rtt_q = 32'd100; last_upd_q = '0; pend_head = 0; pend_count = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    if (mismatches == 0 && awaited.size() == 0)
      $display("ack_credit_gate_test: clean");
    else
      $display("ack_credit_gate_test: errors");
    $finish;
  end

endmodule
